[hw/rtl/packed_reference_base_matcher_macros.svh]
// ---------------------------------------------------------------------------
// Packed reference base matcher: assertion macros
// Shorthand for clocked implication checks with reset masking.
// ---------------------------------------------------------------------------
`ifndef PACKED_REFERENCE_BASE_MATCHER_MACROS_SVH
`define PACKED_REFERENCE_BASE_MATCHER_MACROS_SVH

// Same-cycle implication, masked while rst_n is low.
`define PRBM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while rst_n is low.
`define PRBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/prbm_pkg.sv]
// ---------------------------------------------------------------------------
// prbm_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package prbm_pkg;

  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);

  localparam logic [31:0] REJ_LIMIT = 32'hffff0000;

  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_IW-1:0] CFG_FIRST_POS  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_BASE_COUNT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CMP  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming compare item
    logic mem_write;  // write one store byte from the input ports
    logic setup;      // open a run: window checks
    logic calc_addr;  // genome base position of this read base
    logic calc_byte;  // store byte index and lane
    logic read_mem;   // store read and range flags
    logic compare;    // count, advance, emit result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_active;
  } status_t;

endpackage

[hw/rtl/packed_reference_base_matcher.sv]
// ---------------------------------------------------------------------------
// packed_reference_base_matcher
// Two-bit packed reference store with a read-base match counter.
// ---------------------------------------------------------------------------
//
// Channel   Ports                               Transfer
// -------   ---------------------------------   ------------------------------
// input     start/busy, in_*                    start high while busy low
// result    out_valid, out_match_count,         out_valid high, one cycle,
//           out_window_rejected                 cannot be held off
// config    cfg_we, cfg_index, cfg_wdata        cfg_we high
//
// A store load (in_op = 0) is written at the accepting edge; busy stays low
// and the next item may follow in the very next cycle.
// A compare base steps through the position add, the byte index subtract,
// the store read and then the compare, each into registers, with a setup
// step first when it opens a run; busy stays high until the compare is done,
// so the next item waits for it.
// The result of the last base is strobed on out_valid in the cycle busy drops.
// rst_n is synchronous; the store keeps its contents and needs no clearing.
// ---------------------------------------------------------------------------
module packed_reference_base_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [15:0]                   in_load_address,
  input  logic [7:0]                    in_load_byte,
  input  logic [31:0]                   in_window_start,
  input  logic [15:0]                   in_run_length,
  input  logic                          in_reverse_strand,
  input  logic [7:0]                    in_read_char,
  input  logic                          in_last_base,
  // Result channel
  output logic                          out_valid,
  output logic [15:0]                   out_match_count,
  output logic                          out_window_rejected,
  // Configuration
  input  logic                          cfg_we,
  input  logic [prbm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [prbm_pkg::CFG_DW-1:0]   cfg_wdata
);

  prbm_pkg::cmd_t    cmd;
  prbm_pkg::status_t sts;

  // Sequencer: accept items, step compare bases through the datapath
  prbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Store, run state and compare logic
  prbm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_load_address     (in_load_address),
    .in_load_byte        (in_load_byte),
    .in_window_start     (in_window_start),
    .in_run_length       (in_run_length),
    .in_reverse_strand   (in_reverse_strand),
    .in_read_char        (in_read_char),
    .in_last_base        (in_last_base),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_match_count     (out_match_count),
    .out_window_rejected (out_window_rejected)
  );

endmodule

[hw/rtl/prbm_ctrl.sv]
// ---------------------------------------------------------------------------
// prbm_ctrl
// Sequencer: steps one compare item through address, read and compare.
// ---------------------------------------------------------------------------
module prbm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_op,
  input  prbm_pkg::status_t sts,
  output prbm_pkg::cmd_t   cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_ADDR,
    S_BYTE,
    S_READ,
    S_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_op == prbm_pkg::OP_CMP)) begin
          state_nxt = sts.run_active ? S_ADDR : S_SETUP;
        end
      end
      S_SETUP: state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_BYTE;
      S_BYTE:  state_nxt = S_READ;
      S_READ:  state_nxt = S_CMP;
      S_CMP:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept && (in_op == prbm_pkg::OP_CMP);
    cmd.mem_write = accept && (in_op == prbm_pkg::OP_LOAD);
    cmd.setup     = (state_r == S_SETUP);
    cmd.calc_addr = (state_r == S_ADDR);
    cmd.calc_byte = (state_r == S_BYTE);
    cmd.read_mem  = (state_r == S_READ);
    cmd.compare   = (state_r == S_CMP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

[hw/rtl/prbm_dp.sv]
// ---------------------------------------------------------------------------
// prbm_dp
// Reference store, configuration, run state and base compare datapath.
// ---------------------------------------------------------------------------
module prbm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  prbm_pkg::cmd_t                 cmd,
  output prbm_pkg::status_t              sts,
  input  logic [prbm_pkg::STORE_AW-1:0]  in_load_address,
  input  logic [7:0]                     in_load_byte,
  input  logic [31:0]                    in_window_start,
  input  logic [15:0]                    in_run_length,
  input  logic                           in_reverse_strand,
  input  logic [7:0]                     in_read_char,
  input  logic                           in_last_base,
  input  logic                           cfg_we,
  input  logic [prbm_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [prbm_pkg::CFG_DW-1:0]    cfg_wdata,
  output logic                           out_valid,
  output logic [15:0]                    out_match_count,
  output logic                           out_window_rejected
);

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_G = 2'd1;
  localparam logic [1:0] CODE_C = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // Character a reverse-strand read must carry against reference code c
  function automatic logic [7:0] rev_need(input logic [1:0] c);
    logic [7:0] r;
    case (c)
      CODE_A:  r = CH_T;
      CODE_T:  r = CH_A;
      CODE_G:  r = CH_C;
      CODE_C:  r = CH_G;
      default: r = CH_G;
    endcase
    return r;
  endfunction

  function automatic logic fwd_hit(input logic [7:0] ch, input logic [1:0] c);
    logic h;
    case (ch)
      CH_A:    h = (c == CODE_A);
      CH_G:    h = (c == CODE_G);
      CH_C:    h = (c == CODE_C);
      CH_NUL:  h = 1'b0;
      default: h = (c == CODE_T);
    endcase
    return h;
  endfunction

  // Configuration
  logic [31:0] fbp_r;
  logic [17:0] sbc_r;

  // Latched item
  logic [7:0]  char_r;
  logic        last_r;
  logic [31:0] ws_in_r;
  logic [15:0] len_in_r;
  logic        rev_in_r;

  // Run state
  logic        run_active_r;
  logic [15:0] k_r;
  logic [15:0] cnt_r;
  logic [31:0] start_r;
  logic [15:0] len_r;
  logic        rev_r;
  logic        rej_r;
  logic        void_r;

  // Per-base pipeline
  logic        en_r;
  logic [31:0] p_r;
  logic [29:0] bidx_r;
  logic [1:0]  lane_r;
  logic [7:0]  mem_q_r;
  logic        inrng_r;
  logic        revok_r;
  logic        fwdend_r;

  // Result
  logic        out_valid_r;
  logic [15:0] out_cnt_r;
  logic        out_rej_r;

  localparam int unsigned STORE_BYTES_DEPTH = prbm_pkg::STORE_BYTES;

  logic [7:0] store_mem [STORE_BYTES_DEPTH];

  // Derived from configuration
  logic [31:0] base0;
  logic [31:0] end_pos;
  logic [18:0] span;
  logic [16:0] nbytes;

  assign base0   = {fbp_r[31:2], 2'b00};
  assign end_pos = fbp_r + {14'd0, sbc_r};
  assign span    = {1'b0, sbc_r} + {17'd0, fbp_r[1:0]};
  assign nbytes  = span[18:2] + 17'd1;

  // Setup checks
  logic [31:0] ws_sum;
  logic [31:0] ws_rel;
  logic        setup_rej;
  logic        setup_void;

  assign ws_sum     = ws_in_r + {16'd0, len_in_r};
  assign ws_rel     = ws_in_r - base0;
  assign setup_rej  = (ws_sum >= end_pos) || (ws_in_r > prbm_pkg::REJ_LIMIT);
  assign setup_void = !setup_rej && !rev_in_r && ({2'b00, ws_rel[31:2]} >= {15'd0, nbytes});

  // Compare stage
  logic [7:0]  byte_eff;
  logic [1:0]  code;
  logic        hit;
  logic [15:0] cnt_new;
  logic        void_new;

  assign byte_eff = inrng_r ? mem_q_r : 8'd0;
  assign code     = 2'(byte_eff >> {lane_r, 1'b0});
  assign hit      = rev_r ? (revok_r && (char_r == rev_need(code))) : fwd_hit(char_r, code);
  assign cnt_new  = (en_r && hit) ? cnt_r + 16'd1 : cnt_r;
  assign void_new = void_r || (en_r && !rev_r && fwdend_r);

  logic [31:0] p_rel;
  assign p_rel = p_r - base0;

  // Store: written from the ports, read one byte per base
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      store_mem[in_load_address] <= in_load_byte;
    end
    if (cmd.read_mem) begin
      mem_q_r <= store_mem[bidx_r[prbm_pkg::STORE_AW-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_r   <= in_read_char;
      last_r   <= in_last_base;
      ws_in_r  <= in_window_start;
      len_in_r <= in_run_length;
      rev_in_r <= in_reverse_strand;
    end
    if (cmd.setup) begin
      start_r <= ws_in_r;
      len_r   <= len_in_r;
      rev_r   <= rev_in_r;
    end
    if (cmd.calc_addr) begin
      en_r <= (k_r < len_r) && !rej_r && !void_r;
      if (rev_r) begin
        p_r <= start_r + {16'd0, len_r - 16'd1 - k_r};
      end else begin
        p_r <= start_r + {16'd0, k_r};
      end
    end
    if (cmd.calc_byte) begin
      bidx_r <= p_rel[31:2];
      lane_r <= p_r[1:0];
    end
    if (cmd.read_mem) begin
      inrng_r  <= (bidx_r < 30'(prbm_pkg::STORE_BYTES));
      revok_r  <= (bidx_r < (30'(nbytes) - 30'd1));
      fwdend_r <= (lane_r == 2'd3) && ((bidx_r + 30'd1) == 30'(nbytes));
    end
    if (cmd.compare) begin
      out_cnt_r <= (rej_r || void_new) ? 16'd0 : cnt_new;
      out_rej_r <= rej_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbp_r        <= '0;
      sbc_r        <= '0;
      run_active_r <= 1'b0;
      k_r          <= '0;
      cnt_r        <= '0;
      rej_r        <= 1'b0;
      void_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          prbm_pkg::CFG_FIRST_POS:  fbp_r <= cfg_wdata;
          prbm_pkg::CFG_BASE_COUNT: sbc_r <= cfg_wdata[17:0];
          default: ;
        endcase
      end
      if (cmd.setup) begin
        run_active_r <= 1'b1;
        k_r          <= '0;
        cnt_r        <= '0;
        rej_r        <= setup_rej;
        void_r       <= setup_void;
      end
      if (cmd.compare) begin
        if (last_r) begin
          out_valid_r  <= 1'b1;
          run_active_r <= 1'b0;
          k_r          <= '0;
          cnt_r        <= '0;
          void_r       <= 1'b0;
        end else begin
          cnt_r  <= cnt_new;
          void_r <= void_new;
          if (k_r != 16'hffff) begin
            k_r <= k_r + 16'd1;
          end
        end
      end
    end
  end

  assign sts.run_active     = run_active_r;
  assign out_valid          = out_valid_r;
  assign out_match_count    = out_cnt_r;
  assign out_window_rejected = out_rej_r;

endmodule

[hw/rtl/prbm_checker.sv]
// ---------------------------------------------------------------------------
// prbm_checker
// Port-level checks on the matcher's sequencing and results.
// ---------------------------------------------------------------------------
`include "packed_reference_base_matcher_macros.svh"

module prbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_op,
  input logic        out_valid,
  input logic [15:0] out_match_count,
  input logic        out_window_rejected
);

  `PRBM_ASSERT_NEXT(a_cmp_goes_busy, start && !busy && in_op, busy, "compare did not go busy")
  `PRBM_ASSERT_NEXT(a_load_no_busy, start && !busy && !in_op, !busy && !out_valid, "load stalled")
  `PRBM_ASSERT_SAME(a_result_idle, out_valid, !busy && $past(busy), "result outside a compare")
  `PRBM_ASSERT_SAME(a_reject_zero, out_valid && out_window_rejected, out_match_count == 16'd0, "rejected count not zero")

endmodule

bind packed_reference_base_matcher prbm_checker u_prbm_checker (.*);
